// File: design/mcss_pkg.sv
`default_nettype none

package mcss_pkg;

  // chain size and probability format
  localparam int unsigned MAX_STATES = 16;
  localparam int unsigned PROB_BITS  = 32;
  localparam int unsigned STATE_W    = $clog2(MAX_STATES);
  localparam int unsigned TABLE_AW   = 2 * STATE_W;
  localparam int unsigned ACC_W      = PROB_BITS + STATE_W;

  // field widths fixed by the interface
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_W      = 5;
  localparam int unsigned START_W    = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // register reset values
  localparam logic [NUM_W-1:0]   NUM_STATES_RST  = NUM_W'(2);
  localparam logic [START_W-1:0] START_STATE_RST = '0;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KindLoad  = 2'd0,
    KindStart = 2'd1,
    KindStep  = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CfgNumStates  = 1'd0,
    CfgStartState = 1'd1
  } cfg_idx_e;

  // table port request: one write and one read address per cycle
  typedef struct packed {
    logic                 we;
    logic [TABLE_AW-1:0]  waddr;
    logic [PROB_BITS-1:0] wdata;
    logic [TABLE_AW-1:0]  raddr;
  } tbl_req_t;

  // one step result
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] next_state;
    logic               fell_through;
  } step_res_t;

endpackage

`default_nettype wire

// File: design/mcss_table.sv
`default_nettype none

module mcss_table
  import mcss_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire tbl_req_t             req_i,
  output logic      [PROB_BITS-1:0] rdata_o
);

  logic [PROB_BITS-1:0] mem [MAX_STATES*MAX_STATES];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[req_i.raddr];
  end

endmodule

`default_nettype wire

// File: design/mcss_ctrl.sv
`default_nettype none

module mcss_ctrl
  import mcss_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [KIND_W-1:0]    kind_i,
  input  wire logic [INDEX_W-1:0]   entry_index_i,
  input  wire logic [VALUE_W-1:0]   entry_value_i,
  input  wire logic [VALUE_W-1:0]   random_value_i,
  input  wire logic [NUM_W-1:0]     num_states_i,
  input  wire logic [START_W-1:0]   start_state_i,
  output tbl_req_t                  tbl_req_o,
  input  wire logic [PROB_BITS-1:0] tbl_rdata_i,
  output step_res_t                 res_o
);

  typedef enum logic [1:0] {
    Idle = 2'b01,
    Run  = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [STATE_W-1:0]   cur_q, cur_d;
  logic [STATE_W-1:0]   idx_q, idx_d;
  logic [STATE_W-1:0]   last_q, last_d;
  logic [PROB_BITS-1:0] rnd_q, rnd_d;
  logic [ACC_W-1:0]     total_q, total_d;
  step_res_t            res_q, res_d;

  logic               accept;
  logic [ACC_W-1:0]   sum;
  logic               hit;
  logic               at_last;
  logic [STATE_W-1:0] last_in_use;

  assign busy_o = (state_q != Idle);
  assign accept = start_i && !busy_o;

  // last state in use, with num_states clamped to 1..MAX_STATES
  always_comb begin
    if (num_states_i <= NUM_W'(1)) begin
      last_in_use = '0;
    end else if (num_states_i > NUM_W'(MAX_STATES)) begin
      last_in_use = STATE_W'(MAX_STATES - 1);
    end else begin
      last_in_use = STATE_W'(num_states_i - NUM_W'(1));
    end
  end

  // running total of the row and the hit test
  assign sum     = total_q + ACC_W'(tbl_rdata_i);
  assign hit     = (ACC_W'(rnd_q) <= sum);
  assign at_last = (idx_q == last_q);

  // table port: loads write, steps walk the current row
  always_comb begin
    tbl_req_o.we    = accept && (kind_e'(kind_i) == KindLoad);
    tbl_req_o.waddr = TABLE_AW'(entry_index_i);
    tbl_req_o.wdata = PROB_BITS'(entry_value_i);
    if (state_q == Run) begin
      tbl_req_o.raddr = {cur_q, idx_q + STATE_W'(1)};
    end else begin
      tbl_req_o.raddr = {cur_q, {STATE_W{1'b0}}};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    idx_d   = idx_q;
    last_d  = last_q;
    rnd_d   = rnd_q;
    total_d = total_q;
    res_d   = res_q;
    res_d.valid = 1'b0;
    unique case (state_q)
      Idle: begin
        if (accept) begin
          unique case (kind_e'(kind_i))
            KindStart: begin
              cur_d = STATE_W'(start_state_i);
            end
            KindStep: begin
              idx_d   = '0;
              last_d  = last_in_use;
              rnd_d   = PROB_BITS'(random_value_i);
              total_d = '0;
              state_d = Run;
            end
            default: begin
            end
          endcase
        end
      end
      Run: begin
        total_d = sum;
        if (hit || at_last) begin
          res_d.valid        = 1'b1;
          res_d.next_state   = hit ? idx_q : last_q;
          res_d.fell_through = !hit;
          cur_d              = hit ? idx_q : last_q;
          state_d            = Idle;
        end else begin
          idx_d = idx_q + STATE_W'(1);
        end
      end
      default: begin
        state_d = Idle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= Idle;
      cur_q     <= '0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      res_q     <= res_d;
    end
  end

  // step datapath registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    last_q  <= last_d;
    rnd_q   <= rnd_d;
    total_q <= total_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: design/markov_chain_state_step.sv
`default_nettype none

// Markov chain stepper with an on-chip transition table.
// Items: an item transfers at a rising edge with start_i high and busy_o low.
//   kind load  writes entry_value_i to table entry entry_index_i
//              (from_state * 16 + to_state); no result.
//   kind start makes the configured start state current; no result.
//   kind step  walks the current state's row, one table entry per cycle from
//              the single read port of the table memory, and picks the first
//              state whose running total reaches random_value_i.
// Step: busy_o is high while the row is read, one entry at a time up to the
// hit or the last state in use (num_states clamped to 1..16), and the result
// strobe comes from a register set as the walk ends. Entries never loaded read as anything.
// Result: result_valid_o is high for one cycle with next_state_o and
// fell_through_o; the receiver cannot stall and takes it in that cycle.
// Configuration: cfg_valid_i with cfg_ready_o (always high), index 0 is
// num_states, index 1 is start_state; user writes them only while idle (unenforced).
// Reset: current state 0, num_states 2, start_state 0; the table keeps no
// reset value and needs no clearing pass.
module markov_chain_state_step
  import mcss_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [KIND_W-1:0]     kind_i,
  input  wire logic [INDEX_W-1:0]    entry_index_i,
  input  wire logic [VALUE_W-1:0]    entry_value_i,
  input  wire logic [VALUE_W-1:0]    random_value_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       result_valid_o,
  output logic      [STATE_W-1:0]    next_state_o,
  output logic                       fell_through_o
);

  logic [NUM_W-1:0]     num_states_q;
  logic [START_W-1:0]   start_state_q;
  tbl_req_t             tbl_req;
  logic [PROB_BITS-1:0] tbl_rdata;
  step_res_t            res;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q  <= NUM_STATES_RST;
      start_state_q <= START_STATE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgNumStates:  num_states_q  <= NUM_W'(cfg_data_i);
        CfgStartState: start_state_q <= START_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // sequencer and accumulator
  mcss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .random_value_i (random_value_i),
    .num_states_i   (num_states_q),
    .start_state_i  (start_state_q),
    .tbl_req_o      (tbl_req),
    .tbl_rdata_i    (tbl_rdata),
    .res_o          (res)
  );

  // transition table memory
  mcss_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  assign result_valid_o = res.valid;
  assign next_state_o   = res.next_state;
  assign fell_through_o = res.fell_through;

endmodule

`default_nettype wire

// File: test/markov_chain_state_step_monitor.sv
`timescale 1ns / 100ps

module markov_chain_state_step_monitor
  import mcss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [INDEX_W-1:0]    entry_index_i,
  input  logic [VALUE_W-1:0]    entry_value_i,
  input  logic [VALUE_W-1:0]    random_value_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  result_valid_o,
  input  logic [STATE_W-1:0]    next_state_o,
  input  logic                  fell_through_o,
  output int unsigned           mismatch_count_o,
  output int unsigned           results_due_o
);

  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic               fell_through;
  } step_out_t;

  // shadow of the block: table, registers and current state
  logic [PROB_BITS-1:0] prob_tbl [MAX_STATES*MAX_STATES];
  logic [NUM_W-1:0]     num_reg;
  logic [START_W-1:0]   start_reg;
  logic [STATE_W-1:0]   cur_state;
  step_out_t            steps_due [$];
  int unsigned          mismatches;

  // walk one row in order, first running total at or above the random value wins
  function automatic step_out_t pick_next_state(input logic [STATE_W-1:0] from_state,
                                                input logic [VALUE_W-1:0] rnd);
    logic [ACC_W-1:0] running;
    int unsigned      used;
    logic             found;
    step_out_t        res;
    if (num_reg == '0) used = 1;
    else if (num_reg > NUM_W'(MAX_STATES)) used = MAX_STATES;
    else used = 32'(num_reg);
    res.next_state   = STATE_W'(used - 1);
    res.fell_through = 1'b1;
    running = '0;
    found   = 1'b0;
    for (int unsigned s = 0; s < used; s++) begin
      if (!found) begin
        running = running + ACC_W'(prob_tbl[{from_state, STATE_W'(s)}]);
        if (ACC_W'(rnd) <= running) begin
          res.next_state   = STATE_W'(s);
          res.fell_through = 1'b0;
          found            = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    step_out_t got;
    step_out_t want;
    if (!rst_ni) begin
      num_reg   = NUM_STATES_RST;
      start_reg = START_STATE_RST;
      cur_state = '0;
      steps_due.delete();
      results_due_o <= 0;
    end else begin
      // result transfer, matched against the oldest pending step
      if (result_valid_o) begin
        got.next_state   = next_state_o;
        got.fell_through = fell_through_o;
        if (steps_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("check: result with no step pending, state %0d fell_through %0b",
                     got.next_state, got.fell_through);
        end else begin
          want = steps_due.pop_front();
          if (got.next_state !== want.next_state || got.fell_through !== want.fell_through)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("check: step mismatch, expected state %0d fell_through %0b, %s %0d %0b",
                       want.next_state, want.fell_through, "got", got.next_state,
                       got.fell_through);
          end
        end
      end

      // register write transfer
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgNumStates:  num_reg   = cfg_data_i[NUM_W-1:0];
          CfgStartState: start_reg = cfg_data_i[START_W-1:0];
          default: ;
        endcase
      end

      // item transfer
      if (start_i && !busy_o) begin
        case (kind_e'(kind_i))
          KindLoad:  prob_tbl[entry_index_i] = entry_value_i;
          KindStart: cur_state = start_reg;
          KindStep: begin
            want      = pick_next_state(cur_state, random_value_i);
            cur_state = want.next_state;
            steps_due.push_back(want);
          end
          default: ;
        endcase
      end

      results_due_o <= steps_due.size();
    end
    mismatch_count_o <= mismatches;
  end

endmodule

// File: test/markov_chain_state_step_tb.sv
`timescale 1ns / 100ps

module markov_chain_state_step_tb;
  import mcss_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE       = 24;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 32;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  start_i        = 1'b0;
  logic [KIND_W-1:0]     kind_i         = '0;
  logic [INDEX_W-1:0]    entry_index_i  = '0;
  logic [VALUE_W-1:0]    entry_value_i  = '0;
  logic [VALUE_W-1:0]    random_value_i = '0;
  logic                  cfg_valid_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  busy_o;
  logic                  cfg_ready_o;
  logic                  result_valid_o;
  logic [STATE_W-1:0]    next_state_o;
  logic                  fell_through_o;

  int unsigned mismatch_count;
  int unsigned results_due;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned used_states;

  markov_chain_state_step dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .random_value_i (random_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .next_state_o   (next_state_o),
    .fell_through_o (fell_through_o)
  );

  markov_chain_state_step_monitor step_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .kind_i           (kind_i),
    .entry_index_i    (entry_index_i),
    .entry_value_i    (entry_value_i),
    .random_value_i   (random_value_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .next_state_o     (next_state_o),
    .fell_through_o   (fell_through_o),
    .mismatch_count_o (mismatch_count),
    .results_due_o    (results_due)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // one item transfer, sent in bursts with random gaps between them
  task automatic send_item(input kind_e kind, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] value, input logic [VALUE_W-1:0] rnd);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i        <= 1'b1;
    kind_i         <= kind;
    entry_index_i  <= idx;
    entry_value_i  <= value;
    random_value_i <= rnd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // hold off until every step result is back, then let the block settle
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write both registers, only ever called while idle
  task automatic write_settings(input logic [CFG_DATA_W-1:0] num_data,
                                input logic [CFG_DATA_W-1:0] start_data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgNumStates;
    cfg_data_i  <= num_data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgStartState;
    cfg_data_i  <= start_data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (num_data == '0) used_states = 1;
    else if (num_data > CFG_DATA_W'(MAX_STATES)) used_states = MAX_STATES;
    else used_states = 32'(num_data);
  endtask

  // load a row with a distribution, mostly summing to one, sometimes short
  task automatic write_row(input logic [STATE_W-1:0] row, input int unsigned cols);
    logic [VALUE_W-1:0] remaining;
    logic [VALUE_W-1:0] share;
    remaining = ($urandom_range(0, 9) < 7) ? 32'hFFFF_FFFF : $urandom;
    for (int unsigned c = 0; c < cols; c++) begin
      if (c == cols - 1) share = remaining;
      else if ($urandom_range(0, 4) == 0) share = '0;
      else share = $urandom_range(remaining, 0) >> $urandom_range(0, 3);
      remaining = remaining - share;
      send_item(KindLoad, {row, STATE_W'(c)}, share, $urandom);
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] num_data;
    logic [CFG_DATA_W-1:0] start_data;
    logic [VALUE_W-1:0]    rnd;
    int unsigned           sent;
    int unsigned           pick;

    burst_left  = 0;
    used_states = 32'(NUM_STATES_RST);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: two-state chain at reset settings
    send_item(KindLoad,  8'd0,  32'h0000_0000, 32'h0000_0000);
    send_item(KindLoad,  8'd1,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // zero random value takes state 0 despite its zero probability
    send_item(KindStep,  8'hFF, 32'h0000_0000, 32'h0000_0000);
    send_item(KindStep,  8'h00, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(KindLoad,  8'd16, 32'h8000_0000, 32'h0000_0000);
    send_item(KindLoad,  8'd17, 32'h7FFF_FFFF, 32'h0000_0000);
    // random value equal to the row total
    send_item(KindStep,  8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(KindLoad,  8'd17, 32'h0000_0000, 32'h0000_0000);
    // row total short of the random value, last state with flag
    send_item(KindStep,  8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(KindStep,  8'h00, 32'h0000_0000, 32'h8000_0000);
    // unused kind leaves everything alone
    send_item(KindNone,  8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KindStart, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KindStep,  8'h00, 32'h0000_0000, 32'h8000_0000);
    send_item(KindLoad,  8'hFF, 32'hAAAA_AAAA, 32'h0000_0000);
    send_item(KindLoad,  8'd0,  32'h5555_5555, 32'h0000_0000);
    send_item(KindStart, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_item(KindStep,  8'h00, 32'h0000_0000, 32'h5555_5555);
    send_item(KindStep,  8'h00, 32'h0000_0000, 32'h5555_5556);

    // fill the whole table so no step ever reads an unwritten entry
    for (int unsigned r = 0; r < MAX_STATES; r++) write_row(STATE_W'(r), MAX_STATES);

    // random phases, each with its own register settings
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin num_data = 5'd1;  start_data = 5'd0;  end
        1: begin num_data = 5'd16; start_data = 5'd15; end
        2: begin num_data = 5'd0;  start_data = 5'd5;  end
        3: begin num_data = 5'd31; start_data = 5'd31; end
        4: begin num_data = 5'd17; start_data = 5'd16; end
        5: begin num_data = 5'd2;  start_data = 5'd9;  end
        default: begin
          num_data   = CFG_DATA_W'($urandom_range(0, 31));
          start_data = CFG_DATA_W'($urandom_range(0, 31));
        end
      endcase
      drain();
      write_settings(num_data, start_data);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0:       rnd = '0;
          1:       rnd = '1;
          default: rnd = $urandom;
        endcase
        if (pick < 55) begin
          send_item(KindStep, INDEX_W'($urandom), $urandom, rnd);
          sent++;
        end else if (pick < 70) begin
          write_row(STATE_W'($urandom_range(0, MAX_STATES - 1)), used_states);
          sent += used_states;
        end else if (pick < 80) begin
          send_item(KindStart, INDEX_W'($urandom), $urandom, $urandom);
          sent++;
        end else if (pick < 88) begin
          send_item(KindLoad, INDEX_W'($urandom), $urandom, $urandom);
          sent++;
        end else begin
          send_item(KindNone, INDEX_W'($urandom), $urandom, $urandom);
        end
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    // wind down and give the verdict
    drain();
    if (mismatch_count == 0 && results_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
